// ----- rtl/core/psmc_pkg.sv -----
// Shared types, widths and codes for the PS/2 mouse packet cursor block.
`timescale 1ns / 1ps

package psmc_pkg;

  localparam int BYTE_W         = 8;
  localparam int CFG_W          = 12;
  localparam int OUT_W          = 12;
  localparam int STATUS_W       = 2;
  localparam int COORD_BITS_DEF = 12;

  // Register indexes on the configuration port
  localparam logic CFG_MAX_X = 1'b0;
  localparam logic CFG_MAX_Y = 1'b1;

  localparam logic [CFG_W-1:0] MAX_X_RESET = 12'd800;
  localparam logic [CFG_W-1:0] MAX_Y_RESET = 12'd600;
  localparam int RESET_X = 400;
  localparam int RESET_Y = 300;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_MOVED    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd2;

  // Packet byte bits
  localparam int START_BIT = 3;
  localparam int X_SIGN_BIT = 4;
  localparam int Y_SIGN_BIT = 5;
  localparam int X_OVF_BIT = 6;
  localparam int Y_OVF_BIT = 7;
  localparam int LEFT_BIT = 0;
  localparam int RIGHT_BIT = 1;

  // A complete packet offered by the framer
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] second;
    logic [BYTE_W-1:0] last;
  } pkt_t;

endpackage

// ----- rtl/core/psmc_framer.sv -----
// Input register and three-byte packet framing.
`timescale 1ns / 1ps

module psmc_framer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      byte_valid,
  output logic                      byte_stall,
  input  logic [psmc_pkg::BYTE_W-1:0] data_byte,
  output psmc_pkg::pkt_t            pkt,
  input  logic                      pkt_take
);
  import psmc_pkg::*;

  localparam logic [1:0] IDX_START  = 2'd0;
  localparam logic [1:0] IDX_SECOND = 2'd1;
  localparam logic [1:0] IDX_THIRD  = 2'd2;

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic [1:0]        byte_index;
  logic [1:0]        byte_index_next;
  logic [BYTE_W-1:0] first_byte;
  logic [BYTE_W-1:0] second_byte;
  logic              s1_adv;
  logic              byte_accept;

  // A third byte waits for the result register; any other byte moves on at once
  assign s1_adv      = s1_valid && ((byte_index != IDX_THIRD) || pkt_take);
  assign byte_stall  = s1_valid && !s1_adv;
  assign byte_accept = byte_valid && !byte_stall;

  assign pkt.valid  = s1_valid && (byte_index == IDX_THIRD);
  assign pkt.first  = first_byte;
  assign pkt.second = second_byte;
  assign pkt.last   = s1_byte;

  always_comb begin
    unique case (byte_index)
      IDX_SECOND: byte_index_next = IDX_THIRD;
      IDX_THIRD:  byte_index_next = IDX_START;
      default:    byte_index_next = s1_byte[START_BIT] ? IDX_SECOND : IDX_START;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      byte_index <= IDX_START;
    end else begin
      if (byte_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        byte_index <= byte_index_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_accept) begin
      s1_byte <= data_byte;
    end
    if (s1_adv) begin
      if (byte_index == IDX_SECOND) begin
        second_byte <= s1_byte;
      end else if (byte_index != IDX_THIRD && s1_byte[START_BIT]) begin
        first_byte <= s1_byte;
      end
    end
  end

endmodule

// ----- rtl/core/psmc_cursor.sv -----
// Limit registers, cursor position update and result register.
`timescale 1ns / 1ps

module psmc_cursor #(
  parameter int COORD_BITS = psmc_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [psmc_pkg::CFG_W-1:0]    cfg_wdata,
  input  psmc_pkg::pkt_t                pkt,
  output logic                          pkt_take,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [psmc_pkg::OUT_W-1:0]    cursor_x,
  output logic [psmc_pkg::OUT_W-1:0]    cursor_y,
  output logic                          left_button,
  output logic                          right_button,
  output logic [psmc_pkg::STATUS_W-1:0] packet_status
);
  import psmc_pkg::*;

  // Wide enough for a position plus or minus a 9-bit delta and a 12-bit limit
  localparam int SW = COORD_BITS + 4;
  localparam logic signed [SW-1:0] COORD_MAX = SW'((1 << COORD_BITS) - 1);

  logic [CFG_W-1:0]      max_x;
  logic [CFG_W-1:0]      max_y;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;

  logic signed [8:0]    dx;
  logic signed [8:0]    dy;
  logic signed [SW-1:0] pos_x_ext;
  logic signed [SW-1:0] pos_y_ext;
  logic signed [SW-1:0] nx;
  logic signed [SW-1:0] ny;
  logic signed [SW-1:0] max_x_ext;
  logic signed [SW-1:0] max_y_ext;
  logic signed [SW-1:0] lim_x;
  logic signed [SW-1:0] lim_y;
  logic signed [SW-1:0] cur_x;
  logic signed [SW-1:0] cur_y;
  logic                 overflow;
  logic                 outside;
  logic                 moved;
  logic [STATUS_W-1:0]  status;
  logic                 load;

  assign pkt_take = !result_valid || !result_stall;
  assign load     = pkt.valid && pkt_take;

  assign overflow = pkt.first[X_OVF_BIT] || pkt.first[Y_OVF_BIT];
  assign dx       = $signed({pkt.first[X_SIGN_BIT], pkt.second});
  assign dy       = $signed({pkt.first[Y_SIGN_BIT], pkt.last});

  assign pos_x_ext = $signed({4'b0000, pos_x});
  assign pos_y_ext = $signed({4'b0000, pos_y});
  assign nx        = pos_x_ext + SW'(dx);
  assign ny        = pos_y_ext - SW'(dy);

  assign max_x_ext = $signed({{(SW - CFG_W){1'b0}}, max_x});
  assign max_y_ext = $signed({{(SW - CFG_W){1'b0}}, max_y});
  assign lim_x     = (max_x_ext > COORD_MAX) ? COORD_MAX : max_x_ext;
  assign lim_y     = (max_y_ext > COORD_MAX) ? COORD_MAX : max_y_ext;

  assign outside = nx[SW-1] || ny[SW-1] || (nx > lim_x) || (ny > lim_y);
  assign moved   = !overflow && !outside;
  assign cur_x   = moved ? nx : pos_x_ext;
  assign cur_y   = moved ? ny : pos_y_ext;

  always_comb begin
    if (overflow) begin
      status = ST_OVERFLOW;
    end else if (outside) begin
      status = ST_REJECTED;
    end else begin
      status = ST_MOVED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_x <= MAX_X_RESET;
      max_y <= MAX_Y_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MAX_X: max_x <= cfg_wdata;
        CFG_MAX_Y: max_y <= cfg_wdata;
        default:   max_x <= max_x;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x        <= COORD_BITS'(RESET_X);
      pos_y        <= COORD_BITS'(RESET_Y);
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        pos_x        <= cur_x[COORD_BITS-1:0];
        pos_y        <= cur_y[COORD_BITS-1:0];
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload of the result register
  always_ff @(posedge clk) begin
    if (load) begin
      cursor_x      <= cur_x[OUT_W-1:0];
      cursor_y      <= cur_y[OUT_W-1:0];
      left_button   <= pkt.first[LEFT_BIT];
      right_button  <= pkt.first[RIGHT_BIT];
      packet_status <= status;
    end
  end

endmodule

// ----- rtl/core/ps2_mouse_packet_cursor_unit.sv -----
// Top level of the PS/2 mouse packet decoder with bounded cursor.
`timescale 1ns / 1ps

// Usage:
//   Mouse bytes arrive on the byte channel (byte_valid, byte_stall, data_byte)
//   and one result leaves on the result channel for each complete three-byte
//   packet (cursor_x, cursor_y, left_button, right_button, packet_status).
//   A packet starts only on a byte with bit 3 set; other bytes between packets
//   are dropped without a result.
//   Throughput: one byte per cycle while byte_stall is low. Each byte is taken
//   into an input register and is handled from there by a single add and
//   compare pass. The result of a packet is presented from a result register
//   loaded when its third byte leaves the input register. When the receiver
//   stalls, the result register holds; bytes that end no packet are still
//   taken, and byte_stall rises only once a third byte waits for the occupied
//   result register. Limit registers max_x (index 0) and max_y (index 1) are
//   written through cfg_wr_en, cfg_index and cfg_wdata; the user writes them
//   only while the block is idle, which the block itself does not enforce.
//   Reset (synchronous, active high) empties both registers, restarts the
//   packet framing, sets the cursor to 400, 300 and the limits to 800, 600.
module ps2_mouse_packet_cursor_unit #(
  parameter int COORD_BITS = psmc_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [psmc_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          byte_valid,
  output logic                          byte_stall,
  input  logic [psmc_pkg::BYTE_W-1:0]   data_byte,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [psmc_pkg::OUT_W-1:0]    cursor_x,
  output logic [psmc_pkg::OUT_W-1:0]    cursor_y,
  output logic                          left_button,
  output logic                          right_button,
  output logic [psmc_pkg::STATUS_W-1:0] packet_status
);
  import psmc_pkg::*;

  pkt_t pkt;
  logic pkt_take;

  psmc_framer u_framer (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .data_byte  (data_byte),
    .pkt        (pkt),
    .pkt_take   (pkt_take)
  );

  psmc_cursor #(
    .COORD_BITS (COORD_BITS)
  ) u_cursor (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .pkt           (pkt),
    .pkt_take      (pkt_take),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .cursor_x      (cursor_x),
    .cursor_y      (cursor_y),
    .left_button   (left_button),
    .right_button  (right_button),
    .packet_status (packet_status)
  );

endmodule

// ----- rtl/core/psmc_checker.sv -----
// Port-level checks for the PS/2 mouse packet cursor block, bound to the top level.
`timescale 1ns / 1ps

module psmc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          byte_stall,
  input logic                          result_valid,
  input logic                          result_stall,
  input logic [psmc_pkg::OUT_W-1:0]    cursor_x,
  input logic [psmc_pkg::OUT_W-1:0]    cursor_y,
  input logic                          left_button,
  input logic                          right_button,
  input logic [psmc_pkg::STATUS_W-1:0] packet_status
);
  import psmc_pkg::*;

  // Hold a stalled result
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(cursor_x) &&
      $stable(cursor_y) && $stable(left_button) && $stable(right_button) &&
      $stable(packet_status))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (packet_status == ST_MOVED || packet_status == ST_OVERFLOW ||
      packet_status == ST_REJECTED))
    else $error("result carries an unknown status");

  // Input is only held back by a blocked result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> result_valid && result_stall)
    else $error("byte stalled while the result side is free");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !byte_stall)
    else $error("reset left a transfer pending");

endmodule

bind ps2_mouse_packet_cursor_unit psmc_checker u_checker (.*);

// ----- dv/ps2_mouse_packet_cursor_unit_test.sv -----
// Self-checking testbench for the PS/2 mouse packet cursor unit.
`timescale 1ns / 1ps

module ps2_mouse_packet_cursor_unit_test;
  import psmc_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam int COORD_MAX     = (1 << COORD_BITS_DEF) - 1;

  typedef enum logic [1:0] {
    WAIT_FIRST,
    WAIT_SECOND,
    WAIT_THIRD
  } frame_pos_t;

  typedef struct {
    logic [OUT_W-1:0]    x;
    logic [OUT_W-1:0]    y;
    logic                left;
    logic                right;
    logic [STATUS_W-1:0] status;
  } cursor_report_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic                cfg_index = CFG_MAX_X;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                byte_valid = 1'b0;
  logic                byte_stall;
  logic [BYTE_W-1:0]   data_byte = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic [OUT_W-1:0]    cursor_x;
  logic [OUT_W-1:0]    cursor_y;
  logic                left_button;
  logic                right_button;
  logic [STATUS_W-1:0] packet_status;

  // Predicted block state
  frame_pos_t        frame_pos = WAIT_FIRST;
  logic [BYTE_W-1:0] first_byte = '0;
  logic [BYTE_W-1:0] second_byte = '0;
  int                cur_x = RESET_X;
  int                cur_y = RESET_Y;
  int                lim_x = int'(MAX_X_RESET);
  int                lim_y = int'(MAX_Y_RESET);

  logic [BYTE_W-1:0] mouse_bytes[$];
  cursor_report_t    cursor_reports[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int cycle_count = 0;

  ps2_mouse_packet_cursor_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .data_byte    (data_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cursor_x     (cursor_x),
    .cursor_y     (cursor_y),
    .left_button  (left_button),
    .right_button (right_button),
    .packet_status(packet_status)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  function automatic int delta9(input logic negative, input logic [BYTE_W-1:0] low);
    return negative ? int'(low) - 256 : int'(low);
  endfunction

  function automatic int axis_limit(input int lim);
    return (lim < COORD_MAX) ? lim : COORD_MAX;
  endfunction

  // Track the packet framing and queue the cursor report a third byte produces
  task automatic track_mouse_byte(input logic [BYTE_W-1:0] b);
    cursor_report_t rep;
    int nx;
    int ny;
    case (frame_pos)
      WAIT_SECOND: begin
        second_byte = b;
        frame_pos = WAIT_THIRD;
      end
      WAIT_THIRD: begin
        frame_pos = WAIT_FIRST;
        if (first_byte[X_OVF_BIT] || first_byte[Y_OVF_BIT]) begin
          rep.status = ST_OVERFLOW;
        end else begin
          nx = cur_x + delta9(first_byte[X_SIGN_BIT], second_byte);
          ny = cur_y - delta9(first_byte[Y_SIGN_BIT], b);
          if (nx < 0 || ny < 0 || nx > axis_limit(lim_x) || ny > axis_limit(lim_y)) begin
            rep.status = ST_REJECTED;
          end else begin
            cur_x = nx;
            cur_y = ny;
            rep.status = ST_MOVED;
          end
        end
        rep.x = cur_x[OUT_W-1:0];
        rep.y = cur_y[OUT_W-1:0];
        rep.left = first_byte[LEFT_BIT];
        rep.right = first_byte[RIGHT_BIT];
        cursor_reports.push_back(rep);
      end
      default: begin
        if (b[START_BIT]) begin
          first_byte = b;
          frame_pos = WAIT_SECOND;
        end else begin
          frame_pos = WAIT_FIRST;
        end
      end
    endcase
  endtask

  // Driver: hold a stalled byte, otherwise offer the next one unless idling
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && !byte_stall) begin
        track_mouse_byte(data_byte);
      end
      if (!byte_valid || !byte_stall) begin
        if (mouse_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          byte_valid <= 1'b1;
          data_byte <= mouse_bytes.pop_front();
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    cursor_report_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (cursor_reports.size() == 0) begin
          report_mismatch("unexpected result, status", packet_status, 0);
        end else begin
          want = cursor_reports.pop_front();
          if (cursor_x !== want.x) report_mismatch("cursor_x", cursor_x, want.x);
          if (cursor_y !== want.y) report_mismatch("cursor_y", cursor_y, want.y);
          if (left_button !== want.left) report_mismatch("left_button", left_button, want.left);
          if (right_button !== want.right) begin
            report_mismatch("right_button", right_button, want.right);
          end
          if (packet_status !== want.status) begin
            report_mismatch("packet_status", packet_status, want.status);
          end
        end
      end
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ps2_mouse_packet_cursor_unit regression: fail");
      $finish;
    end
  end

  task automatic push_packet(input logic [BYTE_W-1:0] b0, input logic [BYTE_W-1:0] b1,
                             input logic [BYTE_W-1:0] b2);
    mouse_bytes.push_back(b0);
    mouse_bytes.push_back(b1);
    mouse_bytes.push_back(b2);
  endtask

  function automatic logic [8:0] random_delta();
    if ($urandom_range(3) == 0) return 9'($urandom_range(511));
    return 9'(int'($urandom_range(64)) - 32);
  endfunction

  // Mostly well-formed packets with random motion; some stray and truncated runs
  task automatic push_random_packet();
    logic [8:0] dx;
    logic [8:0] dy;
    logic [BYTE_W-1:0] head;
    int n;
    dx = random_delta();
    dy = random_delta();
    head = {($urandom_range(9) == 0), ($urandom_range(9) == 0), dy[8], dx[8],
            1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1))};
    if ($urandom_range(9) == 0) begin
      mouse_bytes.push_back(8'($urandom_range(255)));
    end
    if ($urandom_range(19) == 0) begin
      n = $urandom_range(2, 1);
      mouse_bytes.push_back(head);
      if (n == 2) mouse_bytes.push_back(dx[7:0]);
    end else begin
      push_packet(head, dx[7:0], dy[7:0]);
    end
  endtask

  task automatic write_limits(input logic [CFG_W-1:0] new_x, input logic [CFG_W-1:0] new_y);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_MAX_X;
    cfg_wdata <= new_x;
    @(posedge clk);
    cfg_index <= CFG_MAX_Y;
    cfg_wdata <= new_y;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    lim_x = int'(new_x);
    lim_y = int'(new_y);
  endtask

  // Hold the sender until every queued byte is taken and every report is back
  task automatic wait_for_idle();
    while (mouse_bytes.size() > 0 || byte_valid || cursor_reports.size() > 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: stray bytes, extreme deltas, buttons, overflow and rejection
    mouse_bytes.push_back(8'h00);
    push_packet(8'h08, 8'h00, 8'h00);
    push_packet(8'h0B, 8'hFF, 8'h00);
    push_packet(8'h38, 8'h00, 8'h00);
    push_packet(8'h08, 8'hFF, 8'hFF);
    push_packet(8'h08, 8'hFF, 8'h00);
    mouse_bytes.push_back(8'hF7);
    push_packet(8'hFF, 8'h12, 8'h34);
    push_packet(8'h48, 8'h55, 8'hAA);
    push_packet(8'h8A, 8'hF7, 8'h08);
    wait_for_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          write_limits(12'hFFF, 12'hFFF);
        end
        1: begin
          send_idle_pct = 86;
          recv_stall_pct = 0;
          write_limits(12'($urandom_range(4095)), 12'($urandom_range(4095)));
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 86;
          write_limits(12'hFFF, 12'h000);
        end
        default: begin
          send_idle_pct = 23;
          recv_stall_pct = 23;
          write_limits(MAX_X_RESET, MAX_Y_RESET);
        end
      endcase
      for (int k = 0; k < 115; k++) push_random_packet();
      wait_for_idle();
    end

    if (mismatches == 0 && cursor_reports.size() == 0) begin
      $display("ps2_mouse_packet_cursor_unit regression: pass");
    end else begin
      $display("ps2_mouse_packet_cursor_unit regression: fail");
    end
    $finish;
  end

endmodule
